FILE: design/affpt_pkg.sv
// Shared types, widths, codes and the output clamp for the affine point transform.
package affpt_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_BITS  = 32;
  localparam int OFFS_BITS  = 48;
  localparam int CFG_BITS   = OFFS_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int MUL_BITS   = 32;

  localparam int PROD_BITS = COORD_BITS + COEF_BITS;
  localparam int SUM_BITS  = ((PROD_BITS > OFFS_BITS) ? PROD_BITS : OFFS_BITS) + 2;
  localparam int DET_BITS  = 2 * COEF_BITS + 1;
  localparam int DX_BITS   =
    ((COORD_BITS + FRAC_BITS > OFFS_BITS) ? COORD_BITS + FRAC_BITS : OFFS_BITS) + 1;
  localparam int DXH_BITS  = DX_BITS - MUL_BITS;
  localparam int PLO_BITS  = MUL_BITS + 1 + COEF_BITS;
  localparam int PHI_BITS  = DXH_BITS + COEF_BITS;
  localparam int NUM_BITS  = DX_BITS + COEF_BITS + 1;
  localparam int DIVD_BITS = NUM_BITS + 2;
  localparam int DVS_BITS  = DET_BITS + 1;
  localparam int REM_BITS  = DVS_BITS + COORD_BITS + 1;
  localparam int MAG_BITS  = SUM_BITS + 1 - FRAC_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_XX  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_XY  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_YX  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_YY  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y = 3'd5;

  localparam logic OP_FORWARD = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SINGULAR  = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  typedef struct packed {
    logic                          opcode;
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  result_x;
    logic signed [COORD_BITS-1:0]  result_y;
    logic [1:0]                    status;
  } out_req_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef_xx;
    logic signed [COEF_BITS-1:0] coef_xy;
    logic signed [OFFS_BITS-1:0] offset_x;
    logic signed [COEF_BITS-1:0] coef_yx;
    logic signed [COEF_BITS-1:0] coef_yy;
    logic signed [OFFS_BITS-1:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic                  opcode;
    logic                  singular;
    logic                  fwd_sat;
    logic [COORD_BITS-1:0] fwd_x;
    logic [COORD_BITS-1:0] fwd_y;
    logic                  neg_x;
    logic                  neg_y;
    logic                  ovf_x;
    logic                  ovf_y;
    logic [DVS_BITS-1:0]   dvs;
    logic [REM_BITS-1:0]   rem_x;
    logic [REM_BITS-1:0]   rem_y;
    logic [COORD_BITS-1:0] q_x;
    logic [COORD_BITS-1:0] q_y;
  } div_t;

  typedef struct packed {
    logic                  sat;
    logic [COORD_BITS-1:0] val;
  } clamp_t;

  // magnitude plus sign to a saturated signed coordinate
  function automatic clamp_t clamp_coord(input logic [MAG_BITS-1:0] mag, input logic neg,
                                         input logic over);
    logic [MAG_BITS-1:0] limit;
    logic [MAG_BITS-1:0] m;
    clamp_t r;
    limit = MAG_BITS'(1) << (COORD_BITS - 1);
    if (!neg) begin
      limit = limit - MAG_BITS'(1);
    end
    r.sat = over || (mag > limit);
    m = r.sat ? limit : mag;
    r.val = neg ? COORD_BITS'(MAG_BITS'(0) - m) : COORD_BITS'(m);
    return r;
  endfunction

endpackage

FILE: design/affine_point_transform_top.sv
// Top level of the affine point transform: config registers, pipeline and output register.
// Takes one request per cycle while the output is not stalled and returns one result per
// request, in order, through 7 front stages (products, sums, rounding, operand setup),
// 32 divider stages (one quotient bit each, for the inverse) and the output register.
// Forward and inverse requests pass through the same stages.
// A stall at the output holds the whole pipeline. Write configuration only while idle.
module affine_point_transform_top import affpt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_req_t                 in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_req_t                out_data,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  cfg_t     cfg;
  logic     adv;
  logic     fr_valid;
  div_t     fr_item;
  logic     dv_valid;
  div_t     dv_item;
  out_req_t res;
  clamp_t   cx, cy;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_xx  <= COEF_BITS'(1) << FRAC_BITS;
      cfg.coef_xy  <= '0;
      cfg.offset_x <= '0;
      cfg.coef_yx  <= '0;
      cfg.coef_yy  <= COEF_BITS'(1) << FRAC_BITS;
      cfg.offset_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_XX:  cfg.coef_xx  <= cfg_data[COEF_BITS-1:0];
        REG_COEF_XY:  cfg.coef_xy  <= cfg_data[COEF_BITS-1:0];
        REG_OFFSET_X: cfg.offset_x <= cfg_data[OFFS_BITS-1:0];
        REG_COEF_YX:  cfg.coef_yx  <= cfg_data[COEF_BITS-1:0];
        REG_COEF_YY:  cfg.coef_yy  <= cfg_data[COEF_BITS-1:0];
        REG_OFFSET_Y: cfg.offset_y <= cfg_data[OFFS_BITS-1:0];
        default: ;
      endcase
    end
  end

  affpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg),
    .div_valid (fr_valid),
    .div_item  (fr_item)
  );

  affpt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (fr_valid),
    .in_item   (fr_item),
    .out_valid (dv_valid),
    .out_item  (dv_item)
  );

  always_comb begin
    cx = clamp_coord(MAG_BITS'(dv_item.q_x), dv_item.neg_x, dv_item.ovf_x);
    cy = clamp_coord(MAG_BITS'(dv_item.q_y), dv_item.neg_y, dv_item.ovf_y);
    if (dv_item.opcode == OP_FORWARD) begin
      res.result_x = dv_item.fwd_x;
      res.result_y = dv_item.fwd_y;
      res.status   = dv_item.fwd_sat ? ST_SATURATED : ST_OK;
    end else if (dv_item.singular) begin
      res.result_x = '0;
      res.result_y = '0;
      res.status   = ST_SINGULAR;
    end else begin
      res.result_x = cx.val;
      res.result_y = cy.val;
      res.status   = (cx.sat || cy.sat) ? ST_SATURATED : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res;
    end
  end

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_SINGULAR)
      |-> (out_data.result_x == '0 && out_data.result_y == '0))
    else $error("singular result carries nonzero coordinates");

endmodule

FILE: design/affpt_front.sv
// Front pipeline: products, sums, forward rounding and divider operand setup.
module affpt_front import affpt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  logic    in_valid,
  input  in_req_t in_data,
  input  cfg_t    cfg,
  output logic    div_valid,
  output div_t    div_item
);

  typedef struct packed {
    logic                  opcode;
    logic                  singular;
    logic                  fwd_sat;
    logic [COORD_BITS-1:0] fwd_x;
    logic [COORD_BITS-1:0] fwd_y;
  } side_t;

  localparam logic [SUM_BITS:0] HALF = (SUM_BITS + 1)'(1) << (FRAC_BITS - 1);

  // stage a
  logic a_valid, a_op;
  logic signed [PROD_BITS-1:0] a_pxa, a_pyb, a_pxd, a_pye;
  logic signed [2*COEF_BITS-1:0] a_ae, a_bd;
  logic signed [DX_BITS-1:0] a_dx, a_dy;
  // stage b
  logic b_valid, b_op;
  logic signed [SUM_BITS-1:0] b_sx, b_sy;
  logic signed [DET_BITS-1:0] b_det;
  logic signed [PLO_BITS-1:0] b_dxe_lo, b_dyb_lo, b_dya_lo, b_dxd_lo;
  logic signed [PHI_BITS-1:0] b_dxe_hi, b_dyb_hi, b_dya_hi, b_dxd_hi;
  // stage c
  logic c_valid;
  side_t c_side;
  logic signed [NUM_BITS-1:0] c_dxe, c_dyb, c_dya, c_dxd;
  logic signed [DET_BITS-1:0] c_det;
  // stage d
  logic d_valid;
  side_t d_side;
  logic signed [NUM_BITS-1:0] d_nx, d_ny;
  logic signed [DET_BITS-1:0] d_det;
  // stage e
  logic e_valid;
  side_t e_side;
  logic [NUM_BITS-1:0] e_anx, e_any;
  logic [DET_BITS-1:0] e_ad;
  logic e_neg_x, e_neg_y;
  // stage f
  logic f_valid;
  side_t f_side;
  logic [DIVD_BITS-1:0] f_nx, f_ny;
  logic [DVS_BITS-1:0] f_dvs;
  logic f_neg_x, f_neg_y;

  logic signed [PROD_BITS-1:0] pxa_c, pyb_c, pxd_c, pye_c;
  logic signed [2*COEF_BITS-1:0] ae_c, bd_c;
  logic signed [DX_BITS-1:0] dx_c, dy_c;
  logic signed [MUL_BITS:0] dx_lo, dy_lo;
  logic signed [DXH_BITS-1:0] dx_hi, dy_hi;
  logic neg_sx, neg_sy;
  logic [SUM_BITS:0] hx, hy;
  clamp_t fcx, fcy;
  logic [REM_BITS-1:0] dvs_top;

  always_comb begin
    pxa_c = in_data.point_x * cfg.coef_xx;
    pyb_c = in_data.point_y * cfg.coef_xy;
    pxd_c = in_data.point_x * cfg.coef_yx;
    pye_c = in_data.point_y * cfg.coef_yy;
    ae_c  = cfg.coef_xx * cfg.coef_yy;
    bd_c  = cfg.coef_xy * cfg.coef_yx;
    dx_c  = (DX_BITS'(in_data.point_x) <<< FRAC_BITS) - DX_BITS'(cfg.offset_x);
    dy_c  = (DX_BITS'(in_data.point_y) <<< FRAC_BITS) - DX_BITS'(cfg.offset_y);
  end

  always_comb begin
    dx_lo = signed'({1'b0, a_dx[MUL_BITS-1:0]});
    dy_lo = signed'({1'b0, a_dy[MUL_BITS-1:0]});
    dx_hi = a_dx[DX_BITS-1:MUL_BITS];
    dy_hi = a_dy[DX_BITS-1:MUL_BITS];
  end

  // round half away from zero: |s| + half, then drop the fraction
  always_comb begin
    neg_sx = b_sx[SUM_BITS-1];
    neg_sy = b_sy[SUM_BITS-1];
    hx = {1'b0, (neg_sx ? ~b_sx : b_sx)} + HALF + (SUM_BITS + 1)'(neg_sx);
    hy = {1'b0, (neg_sy ? ~b_sy : b_sy)} + HALF + (SUM_BITS + 1)'(neg_sy);
    fcx = clamp_coord(MAG_BITS'(hx[SUM_BITS:FRAC_BITS]), neg_sx, 1'b0);
    fcy = clamp_coord(MAG_BITS'(hy[SUM_BITS:FRAC_BITS]), neg_sy, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      div_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      e_valid   <= d_valid;
      f_valid   <= e_valid;
      div_valid <= f_valid;
    end
  end

  always_comb begin
    dvs_top = REM_BITS'(f_dvs) << COORD_BITS;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op  <= in_data.opcode;
      a_pxa <= pxa_c;
      a_pyb <= pyb_c;
      a_pxd <= pxd_c;
      a_pye <= pye_c;
      a_ae  <= ae_c;
      a_bd  <= bd_c;
      a_dx  <= dx_c;
      a_dy  <= dy_c;

      b_op     <= a_op;
      b_sx     <= SUM_BITS'(a_pxa) + SUM_BITS'(a_pyb) + SUM_BITS'(cfg.offset_x);
      b_sy     <= SUM_BITS'(a_pxd) + SUM_BITS'(a_pye) + SUM_BITS'(cfg.offset_y);
      b_det    <= DET_BITS'(a_ae) - DET_BITS'(a_bd);
      b_dxe_lo <= dx_lo * cfg.coef_yy;
      b_dxe_hi <= dx_hi * cfg.coef_yy;
      b_dyb_lo <= dy_lo * cfg.coef_xy;
      b_dyb_hi <= dy_hi * cfg.coef_xy;
      b_dya_lo <= dy_lo * cfg.coef_xx;
      b_dya_hi <= dy_hi * cfg.coef_xx;
      b_dxd_lo <= dx_lo * cfg.coef_yx;
      b_dxd_hi <= dx_hi * cfg.coef_yx;

      c_side.opcode   <= b_op;
      c_side.singular <= (b_det == '0);
      c_side.fwd_sat  <= fcx.sat | fcy.sat;
      c_side.fwd_x    <= fcx.val;
      c_side.fwd_y    <= fcy.val;
      c_dxe <= (NUM_BITS'(b_dxe_hi) <<< MUL_BITS) + NUM_BITS'(b_dxe_lo);
      c_dyb <= (NUM_BITS'(b_dyb_hi) <<< MUL_BITS) + NUM_BITS'(b_dyb_lo);
      c_dya <= (NUM_BITS'(b_dya_hi) <<< MUL_BITS) + NUM_BITS'(b_dya_lo);
      c_dxd <= (NUM_BITS'(b_dxd_hi) <<< MUL_BITS) + NUM_BITS'(b_dxd_lo);
      c_det <= b_det;

      d_side <= c_side;
      d_nx   <= c_dxe - c_dyb;
      d_ny   <= c_dya - c_dxd;
      d_det  <= c_det;

      e_side  <= d_side;
      e_anx   <= d_nx[NUM_BITS-1] ? (NUM_BITS'(0) - d_nx) : d_nx;
      e_any   <= d_ny[NUM_BITS-1] ? (NUM_BITS'(0) - d_ny) : d_ny;
      e_ad    <= d_det[DET_BITS-1] ? (DET_BITS'(0) - d_det) : d_det;
      e_neg_x <= d_nx[NUM_BITS-1] ^ d_det[DET_BITS-1];
      e_neg_y <= d_ny[NUM_BITS-1] ^ d_det[DET_BITS-1];

      f_side  <= e_side;
      f_nx    <= (DIVD_BITS'(e_anx) << 1) + DIVD_BITS'(e_ad);
      f_ny    <= (DIVD_BITS'(e_any) << 1) + DIVD_BITS'(e_ad);
      f_dvs   <= DVS_BITS'(e_ad) << 1;
      f_neg_x <= e_neg_x;
      f_neg_y <= e_neg_y;

      div_item.opcode   <= f_side.opcode;
      div_item.singular <= f_side.singular;
      div_item.fwd_sat  <= f_side.fwd_sat;
      div_item.fwd_x    <= f_side.fwd_x;
      div_item.fwd_y    <= f_side.fwd_y;
      div_item.neg_x    <= f_neg_x;
      div_item.neg_y    <= f_neg_y;
      div_item.ovf_x    <= REM_BITS'(f_nx) >= dvs_top;
      div_item.ovf_y    <= REM_BITS'(f_ny) >= dvs_top;
      div_item.dvs      <= f_dvs;
      div_item.rem_x    <= REM_BITS'(f_nx);
      div_item.rem_y    <= REM_BITS'(f_ny);
      div_item.q_x      <= '0;
      div_item.q_y      <= '0;
    end
  end

  a_det_nonzero: assert property (@(posedge clk) disable iff (rst)
    (e_valid && !e_side.singular) |-> (e_ad != '0))
    else $error("nonzero determinant lost its magnitude");

endmodule

FILE: design/affpt_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing the divisor.
module affpt_div import affpt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  div_t in_item,
  output logic out_valid,
  output div_t out_item
);

  localparam int STEPS = COORD_BITS;

  div_t st [STEPS+1];
  logic [STEPS:0] vld;

  assign st[0]    = in_item;
  assign vld[0]   = in_valid;
  assign out_item = st[STEPS];
  assign out_valid = vld[STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int BIT = STEPS - 1 - k;
    logic [REM_BITS-1:0] sub;
    div_t nxt;

    always_comb begin
      sub = REM_BITS'(st[k].dvs) << BIT;
      nxt = st[k];
      if (st[k].rem_x >= sub) begin
        nxt.rem_x = st[k].rem_x - sub;
        nxt.q_x[BIT] = 1'b1;
      end
      if (st[k].rem_y >= sub) begin
        nxt.rem_y = st[k].rem_y - sub;
        nxt.q_y[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1] <= nxt;
      end
    end
  end

  a_rem_x: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.opcode && !out_item.singular && !out_item.ovf_x)
      |-> (out_item.rem_x < REM_BITS'(out_item.dvs)))
    else $error("x remainder not below divisor");

  a_rem_y: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.opcode && !out_item.singular && !out_item.ovf_y)
      |-> (out_item.rem_y < REM_BITS'(out_item.dvs)))
    else $error("y remainder not below divisor");

endmodule
